// ----- design/k_group_stream_reverser_macros.svh -----
// assertion macros for the k-group stream reverser
// used by k_group_stream_reverser.sv, expects clk and rst in scope
`ifndef K_GROUP_STREAM_REVERSER_MACROS_SVH
`define K_GROUP_STREAM_REVERSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define KSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define KSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ksr_pkg.sv -----
// shared widths, default group depth and reset value for the k-group stream reverser
// no dependencies
package ksr_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 5;
  localparam int MAX_GROUP_DEF = 16;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(2);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CFG_W-1:0]  cfg_t;

endpackage

// ----- design/k_group_stream_reverser.sv -----
// k-group stream reverser top level: group buffer in one ram, emit sequencer
// depends on ksr_pkg, ksr_ram and k_group_stream_reverser_macros.svh
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  s_*     | s_tvalid/s_tready  | tdata value_in, tlast stream_last
//  m_*     | m_tvalid/m_tready  | tdata value_out, tlast run_last,
//          |                    | tuser stream_end
//  cfg_*   | cfg_valid/cfg_ready| cfg_data group_size
//
// an item that only buffers leaves the input open
// an item that closes a run of n values holds the input while all n are read back:
// each result needs one registered ram read and one output register slot
// output stalls hold the emit sequencer, the input stays closed until the run is issued
// synchronous active-high reset empties the group and sets group_size to 2, no sweep
`include "k_group_stream_reverser_macros.svh"

module k_group_stream_reverser #(
  parameter int MAX_GROUP = ksr_pkg::MAX_GROUP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ksr_pkg::data_t       s_tdata,   // [31:0] value_in
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ksr_pkg::data_t       m_tdata,   // [31:0] value_out
  output logic                 m_tlast,
  output logic                 m_tuser,   // [0] stream_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ksr_pkg::cfg_t        cfg_data
);
  import ksr_pkg::*;

  localparam int IDX_W = $clog2(MAX_GROUP);
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state;
  cfg_t             group_size;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] remaining;
  logic             reverse;
  logic             end_flag;
  logic             pend;
  logic             pend_run_last;
  logic             pend_end;
  logic             out_valid;
  data_t            out_data;
  logic             out_run_last;
  logic             out_end;

  logic             in_fire;
  logic             cfg_fire;
  logic             rd_en;
  data_t            rd_data;
  logic [CMP_W-1:0] size_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] eff_size;
  logic [CMP_W-1:0] held;
  logic             full_group;

  assign in_fire   = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective group size, clamped to 1..MAX_GROUP
  assign size_ext = CMP_W'(group_size);
  assign max_ext  = CMP_W'(MAX_GROUP);
  always_comb begin
    if (size_ext == '0) begin
      eff_size = CMP_W'(1);
    end else if (size_ext > max_ext) begin
      eff_size = max_ext;
    end else begin
      eff_size = size_ext;
    end
  end

  // count held after the incoming value is stored
  assign held       = CMP_W'(fill) + CMP_W'(1);
  assign full_group = (held >= eff_size);

  // read the next value while the output slot is free or draining
  assign rd_en = (state == ST_EMIT) && (remaining != '0) && !pend &&
                 (!out_valid || m_tready);

  ksr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_group_ram (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (fill),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RST;
    end else if (cfg_fire) begin
      group_size <= cfg_data;
    end
  end

  // buffering and emit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      remaining <= '0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (full_group || s_tlast) begin
              state     <= ST_EMIT;
              remaining <= CNT_W'(held);
              reverse   <= full_group;
              end_flag  <= s_tlast;
              rd_idx    <= full_group ? fill : '0;
              fill      <= '0;
            end else begin
              fill <= fill + IDX_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if ((remaining == '0) && !pend) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      pend <= rd_en;
      if (rd_en) begin
        remaining     <= remaining - CNT_W'(1);
        rd_idx        <= reverse ? rd_idx - IDX_W'(1) : rd_idx + IDX_W'(1);
        pend_run_last <= (remaining == CNT_W'(1));
        pend_end      <= (remaining == CNT_W'(1)) && end_flag;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_data     <= rd_data;
      out_run_last <= pend_run_last;
      out_end      <= pend_end;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_run_last;
  assign m_tuser  = out_end;

  // checks
  `KSR_ASSERT_NOW(a_pend_slot_free, pend, !out_valid, "read data arrived with output slot full")
  `KSR_ASSERT_NOW(a_emit_fill_clear, state == ST_EMIT, fill == '0, "group not cleared while emitting")
  `KSR_ASSERT_NOW(a_idle_no_work, state == ST_IDLE, (remaining == '0) && !pend, "idle with run pending")
  `KSR_ASSERT_NEXT(a_last_then_idle, rd_en && (remaining == CNT_W'(1)), pend && pend_run_last, "run end lost")

endmodule

// ----- design/ksr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module ksr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// self-checking bench for k_group_stream_reverser: directed table, then random streams
// predicts the reordered words at each input transfer, checks every output transfer
// depends on ksr_pkg and the k_group_stream_reverser rtl
`timescale 1ns / 1ps

module tb_top;
  import ksr_pkg::*;

  localparam int RANDOM_ITEMS  = 385;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_PHASE    = 2;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    data_t value;
    logic  run_last;
    logic  stream_end;
  } result_t;

  typedef struct {
    row_kind_t kind;
    data_t     value;
    logic      tail;
    cfg_t      size;
    logic      typed;
    result_t   want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  s_tvalid = 1'b0;
  logic  s_tready;
  data_t s_tdata = '0;   // [31:0] value_in
  logic  s_tlast = 1'b0; // stream_last
  logic  m_tvalid;
  logic  m_tready = 1'b0;
  data_t m_tdata;        // [31:0] value_out
  logic  m_tlast;        // run_last
  logic  m_tuser;        // [0] stream_end
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  cfg_t  cfg_data = '0;

  // predictor state and expected output words
  data_t   held_words [MAX_GROUP_DEF];
  int      held_count = 0;
  cfg_t    size_reg = GROUP_SIZE_RST;
  result_t awaited_words [$];
  result_t head_word;

  int   mismatches = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;
  logic hold_out = 1'b0;
  cfg_t corner_sizes [6] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd3};

  k_group_stream_reverser uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // group size as the block applies it
  function automatic int capped_size(cfg_t k);
    if (k == 0) return 1;
    if (k > MAX_GROUP_DEF) return MAX_GROUP_DEF;
    return int'(k);
  endfunction

  // buffer one word, emit the held group reversed when full, in order on stream end
  function automatic void reverse_groups_step(data_t v, logic tail, bit emit);
    int      n;
    int      eff;
    bit      full;
    result_t word;
    eff = capped_size(size_reg);
    if (held_count < MAX_GROUP_DEF) begin
      held_words[held_count] = v;
      held_count++;
    end
    n = held_count;
    full = (n >= eff);
    if (full || tail) begin
      for (int i = 0; i < n; i++) begin
        word.value      = full ? held_words[n - 1 - i] : held_words[i];
        word.run_last   = (i == n - 1);
        word.stream_end = (i == n - 1) && tail;
        if (emit) awaited_words.push_back(word);
      end
      held_count = 0;
    end
  endfunction

  function automatic stim_row_t item_row(data_t v, logic tail);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.value = v;
    r.tail  = tail;
    r.size  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // single-result row whose output is written out by hand
  function automatic stim_row_t fixed_row(data_t v, logic tail, result_t want);
    stim_row_t r;
    r = item_row(v, tail);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_t size);
    stim_row_t r;
    r = item_row('0, 1'b0);
    r.kind = ROW_CFG;
    r.size = size;
    return r;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one input transfer, with an optional gap before it
  task automatic send_row(stim_row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r.value;
    s_tlast  <= r.tail;
    do @(posedge clk); while (!s_tready);
    if (r.typed) begin
      reverse_groups_step(r.value, r.tail, 1'b0);
      awaited_words.push_back(r.want);
    end else begin
      reverse_groups_step(r.value, r.tail, 1'b1);
    end
  endtask

  // drain all outputs, let the block settle, then write the group size
  task automatic write_group_size(cfg_t size);
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = size;
  endtask

  // output side: random stall bursts, one long hold on request
  initial begin
    int   burst_left;
    logic stalling;
    burst_left = 0;
    stalling = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (burst_left == 0) begin
          stalling = !calm && ($urandom_range(0, 3) == 0);
          burst_left = stalling ? $urandom_range(1, 15) : $urandom_range(1, 24);
        end
        m_tready <= !stalling || calm;
        burst_left--;
        @(posedge clk);
      end
    end
  end

  // compare each output transfer with the oldest expected word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected output transfer: value_out %h", m_tdata);
        mismatches++;
      end else begin
        head_word = awaited_words.pop_front();
        if (m_tdata !== head_word.value) begin
          $error("value_out expected %h actual %h", head_word.value, m_tdata);
          mismatches++;
        end
        if (m_tlast !== head_word.run_last) begin
          $error("run_last expected %b actual %b", head_word.run_last, m_tlast);
          mismatches++;
        end
        if (m_tuser !== head_word.stream_end) begin
          $error("stream_end expected %b actual %b", head_word.stream_end, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    cfg_t      size;
    int        phase;
    int        random_sent;
    int        phase_items;
    int        run_len;
    int        eff;
    logic      tail;
    logic      open_end;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset size of two: extremes, then a lone word closing the stream
    plan.push_back(item_row(32'h7fff_ffff, 1'b0));
    plan.push_back(item_row(32'h8000_0000, 1'b0));
    plan.push_back(fixed_row(32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b1, 1'b1}));
    // size zero acts as pass-through
    plan.push_back(cfg_row(5'd0));
    plan.push_back(fixed_row(32'hffff_ffff, 1'b0, '{32'hffff_ffff, 1'b1, 1'b0}));
    plan.push_back(fixed_row(32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}));
    // oversize setting clamps to the buffer depth, full group ends the stream
    plan.push_back(cfg_row(5'd31));
    for (int i = 0; i < MAX_GROUP_DEF; i++)
      plan.push_back(item_row(32'h1357_9bd0 + i, i == MAX_GROUP_DEF - 1));
    // size lowered while a group is partly held
    plan.push_back(cfg_row(5'd8));
    plan.push_back(item_row(32'h0000_00a1, 1'b0));
    plan.push_back(item_row(32'hffff_ff5e, 1'b0));
    plan.push_back(item_row(32'h0000_00a3, 1'b0));
    plan.push_back(cfg_row(5'd2));
    plan.push_back(item_row(32'h0000_00a4, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_group_size(plan[i].size);
      else
        send_row(plan[i]);
    end

    // random phases: one group size each, mostly framed streams
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      size = (phase < 6) ? corner_sizes[phase] : cfg_t'($urandom_range(0, 31));
      write_group_size(size);
      if (phase == HOLD_PHASE) hold_out = 1'b1;
      phase_items = $urandom_range(16, 48);
      open_end = ($urandom_range(0, 2) == 0);
      eff = capped_size(size);
      while (phase_items > 0) begin
        run_len = $urandom_range(1, 2 * eff + 2);
        if (run_len > phase_items) run_len = phase_items;
        for (int i = 0; i < run_len; i++) begin
          tail = (i == run_len - 1);
          // occasional broken framing
          if ($urandom_range(0, 11) == 0) tail = !tail;
          // some phases leave a group open across the next size change
          if (phase_items == 1) tail = !open_end;
          row = item_row(pick_value(), tail);
          send_row(row);
          phase_items--;
          random_sent++;
          if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        end
      end
      phase++;
    end

    // drain and report
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
